// ===== rtl/core/usbcds_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the USB configuration descriptor scanner.
// No dependencies; the config registers, step logic and top level import this package.
package usbcds_pkg;

    localparam int unsigned BUFFER_BYTES = 256;
    localparam logic [15:0] BUFFER_LIMIT =
        (BUFFER_BYTES > 65535) ? 16'hFFFF : 16'(BUFFER_BYTES);

    localparam logic [7:0] KIND_CONFIGURATION = 8'h02;
    localparam logic [7:0] KIND_INTERFACE     = 8'h04;
    localparam logic [7:0] KIND_ENDPOINT      = 8'h05;
    localparam logic [7:0] ATTR_BULK_BIT      = 8'h02;
    localparam logic [7:0] EP_DIR_IN          = 8'h80;
    localparam logic [7:0] EP_NUM_MASK        = 8'h0F;

    localparam logic [7:0] CLASS_RESET    = 8'd1;
    localparam logic [7:0] SUBCLASS_RESET = 8'd3;

    typedef enum logic [0:0] {
        CFG_WANTED_CLASS    = 1'b0,
        CFG_WANTED_SUBCLASS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] stream_offset;
        logic [15:0] length_limit;
        logic [7:0]  inner_offset;
        logic [7:0]  descriptor_length;
        logic [7:0]  descriptor_kind;
        logic [7:0]  held_byte_a;
        logic [7:0]  held_byte_b;
        logic [7:0]  config_store;
        logic [11:0] in_slot;
        logic [11:0] out_slot;
        logic [7:0]  endpoint_counter;
        logic        finished;
    } scan_state_t;

    typedef struct packed {
        logic [7:0] wanted_class;
        logic [7:0] wanted_subclass;
    } match_cfg_t;

    localparam scan_state_t STATE_RESET = '{
        stream_offset:     16'd0,
        length_limit:      BUFFER_LIMIT,
        inner_offset:      8'd0,
        descriptor_length: 8'd0,
        descriptor_kind:   8'd0,
        held_byte_a:       8'd0,
        held_byte_b:       8'd0,
        config_store:      8'd0,
        in_slot:           12'd0,
        out_slot:          12'd0,
        endpoint_counter:  8'd1,
        finished:          1'b0
    };

endpackage

// ===== rtl/core/usbcds_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one descriptor byte per word with a restart mark.
// Depends on nothing.
interface usbcds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

// ===== rtl/core/usbcds_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: scanner status after each descriptor byte.
// Depends on nothing.
interface usbcds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] config_value;
    logic [3:0] in_endpoint;
    logic [7:0] in_packet_size;
    logic [3:0] out_endpoint;
    logic [7:0] out_packet_size;
    logic [7:0] endpoint_total;
    logic       parse_done;

    modport source (
        output valid, output config_value, output in_endpoint, output in_packet_size,
        output out_endpoint, output out_packet_size, output endpoint_total,
        output parse_done, input ready
    );
    modport sink (
        input valid, input config_value, input in_endpoint, input in_packet_size,
        input out_endpoint, input out_packet_size, input endpoint_total,
        input parse_done, output ready
    );
endinterface

// ===== rtl/core/usbcds_cfg_regs.sv =====
`timescale 1ns / 1ps
// Match configuration registers: wanted interface class and subclass.
// Depends on usbcds_pkg.
module usbcds_cfg_regs
    import usbcds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    output match_cfg_t match_cfg
);

    match_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wanted_class    <= CLASS_RESET;
            cfg_reg.wanted_subclass <= SUBCLASS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WANTED_CLASS:    cfg_reg.wanted_class    <= cfg_data;
                CFG_WANTED_SUBCLASS: cfg_reg.wanted_subclass <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign match_cfg = cfg_reg;

endmodule

// ===== rtl/core/usbcds_step.sv =====
`timescale 1ns / 1ps
// Next-state logic of the descriptor walk for one byte.
// Depends on usbcds_pkg.
module usbcds_step
    import usbcds_pkg::*;
(
    input  scan_state_t state,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  match_cfg_t  match_cfg,
    output scan_state_t state_next
);

    scan_state_t cur;
    scan_state_t nxt;
    logic [11:0] slot;

    always_comb
    begin
        cur  = first_byte ? STATE_RESET : state;
        nxt  = cur;
        slot = {nxt.held_byte_a[3:0], data_byte};
        if (!cur.finished)
        begin
            if (cur.stream_offset == 16'd2)
            begin
                nxt.held_byte_b = data_byte;
            end
            else if (cur.stream_offset == 16'd3)
            begin
                nxt.length_limit = ({data_byte, nxt.held_byte_b} > BUFFER_LIMIT) ?
                                   BUFFER_LIMIT : {data_byte, nxt.held_byte_b};
            end

            if (cur.inner_offset == 8'd0)
            begin
                nxt.descriptor_length = data_byte;
                nxt.descriptor_kind   = 8'd0;
                if (data_byte == 8'd0)
                begin
                    nxt.finished = 1'b1;
                end
            end
            else if (cur.inner_offset == 8'd1)
            begin
                nxt.descriptor_kind = data_byte;
            end
            else if (cur.descriptor_kind == KIND_CONFIGURATION)
            begin
                if (cur.inner_offset == 8'd5)
                begin
                    nxt.config_store = data_byte;
                end
            end
            else if (cur.descriptor_kind == KIND_INTERFACE)
            begin
                if (cur.inner_offset == 8'd5)
                begin
                    nxt.held_byte_a = data_byte;
                end
                else if (cur.inner_offset == 8'd6)
                begin
                    if (nxt.held_byte_a != match_cfg.wanted_class ||
                        data_byte != match_cfg.wanted_subclass)
                    begin
                        nxt.config_store = 8'd0;
                        nxt.finished     = 1'b1;
                    end
                end
            end
            else if (cur.descriptor_kind == KIND_ENDPOINT)
            begin
                if (cur.inner_offset == 8'd2)
                begin
                    nxt.held_byte_a = data_byte;
                end
                else if (cur.inner_offset == 8'd3)
                begin
                    nxt.held_byte_b = data_byte;
                end
                else if (cur.inner_offset == 8'd4 &&
                         (nxt.held_byte_b & ATTR_BULK_BIT) != 8'd0)
                begin
                    if ((nxt.held_byte_a & EP_DIR_IN) != 8'd0)
                    begin
                        nxt.in_slot = slot;
                    end
                    else
                    begin
                        nxt.out_slot = slot;
                    end
                    if (nxt.endpoint_counter != 8'hFF)
                    begin
                        nxt.endpoint_counter = nxt.endpoint_counter + 8'd1;
                    end
                end
            end

            if (nxt.descriptor_length != 8'd0)
            begin
                nxt.inner_offset = cur.inner_offset + 8'd1;
                if (nxt.inner_offset >= nxt.descriptor_length)
                begin
                    nxt.inner_offset = 8'd0;
                end
            end

            if (cur.stream_offset != 16'hFFFF)
            begin
                nxt.stream_offset = cur.stream_offset + 16'd1;
            end
            if (nxt.stream_offset >= nxt.length_limit)
            begin
                nxt.finished = 1'b1;
            end
        end
        state_next = nxt;
    end

endmodule

// ===== rtl/core/usb_config_descriptor_scanner_top.sv =====
`timescale 1ns / 1ps
// USB configuration descriptor scanner, top level. An accepted byte is captured
// in the input register, and its updated state is stored in the result register.
// Throughput: one word per cycle while the result channel is not stalled, set by
// the combinational state update between the registers. Reset clears the parse
// state, sets wanted class 1 and subclass 3. Depends on usbcds_pkg and the ifs.
module usb_config_descriptor_scanner_top
    import usbcds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    usbcds_in_if.sink    desc,
    usbcds_out_if.source res,
    input  logic         cfg_write_en,
    input  logic [0:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_first_reg;
    logic        out_valid_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t result_reg;
    match_cfg_t  match_cfg;
    logic        advance;

    usbcds_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .match_cfg    (match_cfg)
    );

    usbcds_step u_step (
        .state      (state_reg),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .match_cfg  (match_cfg),
        .state_next (state_next)
    );

    assign advance    = !out_valid_reg || res.ready;
    assign desc.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (desc.ready)
            begin
                in_valid_reg <= desc.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc.ready && desc.valid)
        begin
            in_data_reg  <= desc.data_byte;
            in_first_reg <= desc.first_byte;
        end
        if (advance && in_valid_reg)
        begin
            result_reg <= state_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.config_value    = result_reg.config_store;
    assign res.in_endpoint     = result_reg.in_slot[11:8];
    assign res.in_packet_size  = result_reg.in_slot[7:0];
    assign res.out_endpoint    = result_reg.out_slot[11:8];
    assign res.out_packet_size = result_reg.out_slot[7:0];
    assign res.endpoint_total  = result_reg.endpoint_counter;
    assign res.parse_done      = result_reg.finished;

    a_counter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.endpoint_counter != 8'd0)
        else $error("endpoint counter reached zero");

    a_inner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.descriptor_length == 8'd0 && state_reg.inner_offset == 8'd0) ||
        (state_reg.inner_offset < state_reg.descriptor_length))
        else $error("inner offset outside descriptor");

    a_total_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.length_limit <= BUFFER_LIMIT)
        else $error("total length above buffer limit");

    a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && state_reg.finished && !in_first_reg)
        |=> $stable(state_reg.stream_offset))
        else $error("offset moved after parse end");

endmodule
